// File: hw/rtl/mcta_pkg.sv
// Shared types and constants of the min-cost track assignment block.
// Holds operation codes, cost limits and the controller/datapath command
// and status structs. No dependencies.
package mcta_pkg;

  localparam int COST_W = 25;
  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};
  localparam logic [COST_W-1:0] TOL_RESET = 25'd1024;
  localparam int OUT_DW = 40;

  localparam logic [1:0] OP_LOAD_TRK = 2'd0;
  localparam logic [1:0] OP_LOAD_DET = 2'd1;
  localparam logic [1:0] OP_SOLVE    = 2'd2;

  localparam logic [0:0] REG_TOL = 1'b0;

  typedef struct packed {
    logic idle;
    logic fill_rd;
    logic fill_diff;
    logic fill_mul;
    logic fill_sqrt;
    logic fill_wr;
    logic clr;
    logic ph_rd;
    logic ph_wr;
    logic cur_rd;
    logic cur_ex;
    logic sc_rd;
    logic sc_ex;
    logic up_rd;
    logic up_ex;
    logic aug_rd1;
    logic aug_rd2;
    logic aug_wr;
    logic res_rd;
    logic res_ca;
    logic res_wr;
    logic emit_rd;
    logic emit_show;
    logic empty_show;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic solve_go;
    logic det_zero;
    logic track_zero;
    logic mul_last;
    logic sqrt_last;
    logic cell_last;
    logic j_last;
    logic owner_zero;
    logic prev_zero;
    logic i_last;
    logic k_last;
    logic out_fire;
  } sts_t;

endpackage

// File: hw/rtl/mcta_ctrl.sv
// Sequencer of the min-cost track assignment block.
// One-hot state machine issuing commands to mcta_datapath; uses mcta_pkg.
module mcta_ctrl
  import mcta_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [24:0] {
    S_IDLE       = 25'h0000001,
    S_FILL_RD    = 25'h0000002,
    S_FILL_DIFF  = 25'h0000004,
    S_FILL_MUL   = 25'h0000008,
    S_FILL_SQRT  = 25'h0000010,
    S_FILL_WR    = 25'h0000020,
    S_CLR        = 25'h0000040,
    S_PH_RD      = 25'h0000080,
    S_PH_WR      = 25'h0000100,
    S_CUR_RD     = 25'h0000200,
    S_CUR_EX     = 25'h0000400,
    S_SC_RD      = 25'h0000800,
    S_SC_EX      = 25'h0001000,
    S_UP_RD      = 25'h0002000,
    S_UP_EX      = 25'h0004000,
    S_AUG_RD1    = 25'h0008000,
    S_AUG_RD2    = 25'h0010000,
    S_AUG_WR     = 25'h0020000,
    S_RES_RD     = 25'h0040000,
    S_RES_CA     = 25'h0080000,
    S_RES_WR     = 25'h0100000,
    S_EMIT_RD    = 25'h0200000,
    S_EMIT_SHOW  = 25'h0400000,
    S_EMPTY_SHOW = 25'h0800000,
    S_DONE       = 25'h1000000
  } state_t;

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (sts.solve_go) begin
          if (sts.det_zero) state_nxt = S_EMPTY_SHOW;
          else if (sts.track_zero) state_nxt = S_EMIT_RD;
          else state_nxt = S_FILL_RD;
        end
      end
      S_FILL_RD:   state_nxt = S_FILL_DIFF;
      S_FILL_DIFF: state_nxt = S_FILL_MUL;
      S_FILL_MUL:  if (sts.mul_last) state_nxt = S_FILL_SQRT;
      S_FILL_SQRT: if (sts.sqrt_last) state_nxt = S_FILL_WR;
      S_FILL_WR:   state_nxt = sts.cell_last ? S_CLR : S_FILL_RD;
      S_CLR:       if (sts.j_last) state_nxt = S_PH_RD;
      S_PH_RD:     state_nxt = S_PH_WR;
      S_PH_WR:     state_nxt = sts.j_last ? S_CUR_RD : S_PH_RD;
      S_CUR_RD:    state_nxt = S_CUR_EX;
      S_CUR_EX:    state_nxt = sts.owner_zero ? S_AUG_RD1 : S_SC_RD;
      S_SC_RD:     state_nxt = S_SC_EX;
      S_SC_EX:     state_nxt = sts.j_last ? S_UP_RD : S_SC_RD;
      S_UP_RD:     state_nxt = S_UP_EX;
      S_UP_EX:     state_nxt = sts.j_last ? S_CUR_RD : S_UP_RD;
      S_AUG_RD1:   state_nxt = S_AUG_RD2;
      S_AUG_RD2:   state_nxt = S_AUG_WR;
      S_AUG_WR: begin
        if (sts.prev_zero) state_nxt = sts.i_last ? S_RES_RD : S_PH_RD;
        else state_nxt = S_AUG_RD1;
      end
      S_RES_RD:    state_nxt = S_RES_CA;
      S_RES_CA:    state_nxt = S_RES_WR;
      S_RES_WR:    state_nxt = sts.j_last ? S_EMIT_RD : S_RES_RD;
      S_EMIT_RD:   state_nxt = S_EMIT_SHOW;
      S_EMIT_SHOW: if (sts.out_fire) state_nxt = sts.k_last ? S_DONE : S_EMIT_RD;
      S_EMPTY_SHOW: if (sts.out_fire) state_nxt = S_DONE;
      S_DONE:      state_nxt = S_IDLE;
      default:     state_nxt = S_IDLE;
    endcase
  end

  assign cmd.idle       = (state_r == S_IDLE);
  assign cmd.fill_rd    = (state_r == S_FILL_RD);
  assign cmd.fill_diff  = (state_r == S_FILL_DIFF);
  assign cmd.fill_mul   = (state_r == S_FILL_MUL);
  assign cmd.fill_sqrt  = (state_r == S_FILL_SQRT);
  assign cmd.fill_wr    = (state_r == S_FILL_WR);
  assign cmd.clr        = (state_r == S_CLR);
  assign cmd.ph_rd      = (state_r == S_PH_RD);
  assign cmd.ph_wr      = (state_r == S_PH_WR);
  assign cmd.cur_rd     = (state_r == S_CUR_RD);
  assign cmd.cur_ex     = (state_r == S_CUR_EX);
  assign cmd.sc_rd      = (state_r == S_SC_RD);
  assign cmd.sc_ex      = (state_r == S_SC_EX);
  assign cmd.up_rd      = (state_r == S_UP_RD);
  assign cmd.up_ex      = (state_r == S_UP_EX);
  assign cmd.aug_rd1    = (state_r == S_AUG_RD1);
  assign cmd.aug_rd2    = (state_r == S_AUG_RD2);
  assign cmd.aug_wr     = (state_r == S_AUG_WR);
  assign cmd.res_rd     = (state_r == S_RES_RD);
  assign cmd.res_ca     = (state_r == S_RES_CA);
  assign cmd.res_wr     = (state_r == S_RES_WR);
  assign cmd.emit_rd    = (state_r == S_EMIT_RD);
  assign cmd.emit_show  = (state_r == S_EMIT_SHOW);
  assign cmd.empty_show = (state_r == S_EMPTY_SHOW);
  assign cmd.done       = (state_r == S_DONE);

endmodule

// File: hw/rtl/mcta_datapath.sv
// Datapath of the min-cost track assignment block: position and cost stores,
// distance unit with iterative square root, column potentials and results.
// Driven by mcta_ctrl; uses mcta_pkg.
module mcta_datapath
  import mcta_pkg::*;
#(
  parameter int MAX_ITEMS  = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  output sts_t                    sts,
  input  logic                    in_tvalid,
  input  logic [1:0]              in_op,
  input  logic [3*COORD_BITS-1:0] in_pos,
  input  logic                    out_tready,
  input  logic [COST_W-1:0]       tol,
  output logic [3:0]              o_det_idx,
  output logic [3:0]              o_trk_idx,
  output logic                    o_matched,
  output logic [COST_W-1:0]       o_cost,
  output logic                    o_empty,
  output logic                    o_ovf
);

  localparam int CB = COORD_BITS;
  localparam int IW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);
  localparam int PW = COST_W + CW + 3;
  localparam int EW = (CB + 1 > 26) ? CB + 1 : 26;
  localparam int CD = 1 << (2 * IW);
  localparam logic [CW-1:0] MAXC = CW'(MAX_ITEMS);
  localparam logic signed [PW-1:0] SMAX = {1'b0, {(PW-1){1'b1}}};

  logic [CW-1:0] trk_cnt_r, det_cnt_r, dim;
  logic          ovf_r;
  logic [3*CB-1:0] trk_mem [MAX_ITEMS];
  logic [3*CB-1:0] det_mem [MAX_ITEMS];
  logic [3*CB-1:0] trk_q_r, det_q_r;
  logic [COST_W-1:0] cost_mem [CD];
  logic [COST_W-1:0] cost_q_r;
  logic [2*IW-1:0] cost_ra;

  logic [IW-1:0] d_r, t_r, k_r, res_r;
  logic [1:0]    m_r;
  logic [24:0]   ab_r [3];
  logic          far_r;
  logic [51:0]   acc_r, rem_r, root_r, bit_r;
  logic [CW-1:0] j_r, i_r, cur_r, next_r, row_r;
  logic signed [PW-1:0] ucur_r, delta_r;
  logic          cz_r, resv_r;
  logic [MAX_ITEMS-1:0] match_r;
  logic          match_q_r;
  logic [IW-1:0] res_trk_mem [MAX_ITEMS];
  logic [COST_W-1:0] res_cost_mem [MAX_ITEMS];
  logic [IW-1:0] res_trk_q_r;
  logic [COST_W-1:0] res_cost_q_r;

  logic signed [PW-1:0] v_mem [MAX_ITEMS+1];
  logic signed [PW-1:0] uc_mem [MAX_ITEMS+1];
  logic signed [PW-1:0] slk_mem [MAX_ITEMS+1];
  logic [CW-1:0] own_mem [MAX_ITEMS+1];
  logic [CW-1:0] pred_mem [MAX_ITEMS+1];
  logic          seen_mem [MAX_ITEMS+1];
  logic signed [PW-1:0] q_v, q_uc, q_slk, w_v, w_uc, w_slk, h_v, h_slk;
  logic [CW-1:0] q_own, q_pred, w_own, w_pred, h_pred, col_ra, col_wa;
  logic          q_seen, w_seen, h_seen, col_we;

  logic          in_fire, load_trk, load_det;
  logic signed [CB:0] dx [3];
  logic [EW-1:0] axe [3];
  logic [24:0]   ab_sel;
  logic [49:0]   sq;
  logic [51:0]   acc_sum, rb;
  logic [COST_W-1:0] cost_w;
  logic signed [PW-1:0] cell_s, red, sc_slk;
  logic          sc_take;

  assign dim      = (det_cnt_r > trk_cnt_r) ? det_cnt_r : trk_cnt_r;
  assign in_fire  = in_tvalid & cmd.idle;
  assign load_trk = in_fire && (in_op == OP_LOAD_TRK) && (trk_cnt_r != MAXC);
  assign load_det = in_fire && (in_op == OP_LOAD_DET) && (det_cnt_r != MAXC);

  always_ff @(posedge clk) begin
    if (load_trk) trk_mem[trk_cnt_r[IW-1:0]] <= in_pos;
    if (load_det) det_mem[det_cnt_r[IW-1:0]] <= in_pos;
    trk_q_r <= trk_mem[t_r];
    det_q_r <= det_mem[d_r];
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      dx[a]  = $signed({det_q_r[a*CB+CB-1], det_q_r[a*CB +: CB]}) -
               $signed({trk_q_r[a*CB+CB-1], trk_q_r[a*CB +: CB]});
      axe[a] = EW'(dx[a][CB] ? (CB+1)'(-dx[a]) : (CB+1)'(dx[a]));
    end
  end

  assign ab_sel  = ab_r[m_r];
  assign sq      = ab_sel * ab_sel;
  assign acc_sum = acc_r + 52'(sq);
  assign rb      = root_r + bit_r;
  assign cost_w  = (far_r || (root_r > 52'(COST_MAX))) ? COST_MAX : root_r[COST_W-1:0];

  always_comb begin
    cost_ra = {IW'(row_r - CW'(1)), IW'(j_r - CW'(1))};
    if (cmd.res_ca) cost_ra = {IW'(q_own - CW'(1)), IW'(j_r - CW'(1))};
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_wr) cost_mem[{d_r, t_r}] <= cost_w;
    cost_q_r <= cost_mem[cost_ra];
  end

  // column records
  assign cell_s  = cz_r ? '0 : PW'(cost_q_r);
  assign red     = cell_s - ucur_r - q_v;
  assign sc_take = !q_seen && (red < q_slk);
  assign sc_slk  = sc_take ? red : q_slk;

  always_comb begin
    col_ra = j_r;
    if (cmd.cur_rd || cmd.aug_rd1) col_ra = cur_r;
    if (cmd.aug_rd2) col_ra = q_pred;
    col_we = 1'b0;
    col_wa = j_r;
    w_v = q_v; w_uc = q_uc; w_slk = q_slk; w_own = q_own; w_pred = q_pred; w_seen = q_seen;
    if (cmd.clr) begin
      col_we = 1'b1;
      w_v = '0; w_uc = '0; w_slk = '0; w_own = '0; w_pred = '0; w_seen = 1'b0;
    end
    if (cmd.ph_wr) begin
      col_we = 1'b1;
      w_slk  = SMAX;
      w_seen = 1'b0;
      if (j_r == '0) begin
        w_own = i_r;
        w_uc  = '0;
      end
    end
    if (cmd.cur_ex) begin
      col_we = (q_own != '0);
      col_wa = cur_r;
      w_seen = 1'b1;
    end
    if (cmd.sc_ex) begin
      col_we = 1'b1;
      w_slk  = sc_slk;
      if (sc_take) w_pred = cur_r;
    end
    if (cmd.up_ex) begin
      col_we = 1'b1;
      if (q_seen) begin
        w_uc = q_uc + delta_r;
        w_v  = q_v - delta_r;
      end else begin
        w_slk = q_slk - delta_r;
      end
    end
    if (cmd.aug_wr) begin
      col_we = 1'b1;
      col_wa = cur_r;
      w_v = h_v; w_slk = h_slk; w_pred = h_pred; w_seen = h_seen;
    end
  end

  always_ff @(posedge clk) begin
    if (col_we) begin
      v_mem[col_wa]    <= w_v;
      uc_mem[col_wa]   <= w_uc;
      slk_mem[col_wa]  <= w_slk;
      own_mem[col_wa]  <= w_own;
      pred_mem[col_wa] <= w_pred;
      seen_mem[col_wa] <= w_seen;
    end
    q_v    <= v_mem[col_ra];
    q_uc   <= uc_mem[col_ra];
    q_slk  <= slk_mem[col_ra];
    q_own  <= own_mem[col_ra];
    q_pred <= pred_mem[col_ra];
    q_seen <= seen_mem[col_ra];
  end

  // per-detection results
  always_ff @(posedge clk) begin
    if (cmd.res_wr && resv_r && (cost_q_r <= tol)) begin
      res_trk_mem[res_r]  <= IW'(j_r - CW'(1));
      res_cost_mem[res_r] <= cost_q_r;
    end
    res_trk_q_r  <= res_trk_mem[k_r];
    res_cost_q_r <= res_cost_mem[k_r];
  end

  always_ff @(posedge clk) begin
    if (cmd.fill_diff) begin
      for (int a = 0; a < 3; a++) ab_r[a] <= axe[a][24:0];
      far_r <= (|axe[0][EW-1:25]) | (|axe[1][EW-1:25]) | (|axe[2][EW-1:25]);
    end
    if (cmd.aug_rd2) begin
      h_v <= q_v; h_slk <= q_slk; h_pred <= q_pred; h_seen <= q_seen;
    end
    if (cmd.sc_rd) cz_r <= (row_r > det_cnt_r) || (j_r > trk_cnt_r);
    if (cmd.res_ca) begin
      resv_r <= (q_own != '0) && (q_own <= det_cnt_r) && (j_r <= trk_cnt_r);
      res_r  <= IW'(q_own - CW'(1));
    end
    if (cmd.cur_ex) begin
      ucur_r <= q_uc;
      row_r  <= q_own;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trk_cnt_r <= '0; det_cnt_r <= '0; ovf_r <= 1'b0;
      d_r <= '0; t_r <= '0; k_r <= '0; m_r <= '0;
      j_r <= '0; i_r <= '0; cur_r <= '0; next_r <= '0;
      delta_r <= SMAX; match_r <= '0; match_q_r <= 1'b0;
      acc_r <= '0; rem_r <= '0; root_r <= '0; bit_r <= '0;
    end else begin
      match_q_r <= match_r[k_r];
      if (load_trk) trk_cnt_r <= trk_cnt_r + CW'(1);
      if (load_det) det_cnt_r <= det_cnt_r + CW'(1);
      if (in_fire && (in_op == OP_LOAD_TRK) && (trk_cnt_r == MAXC)) ovf_r <= 1'b1;
      if (in_fire && (in_op == OP_LOAD_DET) && (det_cnt_r == MAXC)) ovf_r <= 1'b1;
      if (sts.solve_go) begin
        d_r <= '0; t_r <= '0; k_r <= '0; j_r <= '0; match_r <= '0;
      end
      if (cmd.fill_diff) begin
        m_r <= '0; acc_r <= '0;
      end
      if (cmd.fill_mul) begin
        m_r   <= m_r + 2'd1;
        acc_r <= acc_sum;
        if (sts.mul_last) begin
          rem_r <= acc_sum; root_r <= '0; bit_r <= 52'd1 << 50;
        end
      end
      if (cmd.fill_sqrt) begin
        if (rem_r >= rb) begin
          rem_r  <= rem_r - rb;
          root_r <= (root_r >> 1) + bit_r;
        end else begin
          root_r <= root_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      if (cmd.fill_wr) begin
        if (CW'(t_r) + CW'(1) == trk_cnt_r) begin
          t_r <= '0; d_r <= d_r + IW'(1);
        end else begin
          t_r <= t_r + IW'(1);
        end
      end
      if (cmd.clr) begin
        if (sts.j_last) begin
          j_r <= '0; i_r <= CW'(1);
        end else begin
          j_r <= j_r + CW'(1);
        end
      end
      if (cmd.ph_wr) begin
        if (sts.j_last) cur_r <= '0;
        else j_r <= j_r + CW'(1);
      end
      if (cmd.cur_ex) begin
        j_r <= CW'(1); delta_r <= SMAX; next_r <= '0;
      end
      if (cmd.sc_ex) begin
        if (!q_seen && (sc_slk < delta_r)) begin
          delta_r <= sc_slk; next_r <= j_r;
        end
        j_r <= sts.j_last ? '0 : j_r + CW'(1);
      end
      if (cmd.up_ex) begin
        if (sts.j_last) cur_r <= next_r;
        else j_r <= j_r + CW'(1);
      end
      if (cmd.aug_wr) begin
        cur_r <= h_pred;
        if (sts.prev_zero) begin
          if (sts.i_last) begin
            j_r <= CW'(1);
          end else begin
            i_r <= i_r + CW'(1); j_r <= '0;
          end
        end
      end
      if (cmd.res_wr) begin
        if (resv_r && (cost_q_r <= tol)) match_r[res_r] <= 1'b1;
        if (sts.j_last) k_r <= '0;
        else j_r <= j_r + CW'(1);
      end
      if (cmd.emit_show && sts.out_fire && !sts.k_last) k_r <= k_r + IW'(1);
      if (cmd.done) begin
        trk_cnt_r <= '0; det_cnt_r <= '0; ovf_r <= 1'b0;
      end
    end
  end

  assign sts.solve_go   = in_fire && (in_op == OP_SOLVE);
  assign sts.det_zero   = (det_cnt_r == '0);
  assign sts.track_zero = (trk_cnt_r == '0);
  assign sts.mul_last   = (m_r == 2'd2);
  assign sts.sqrt_last  = bit_r[0];
  assign sts.cell_last  = (CW'(t_r) + CW'(1) == trk_cnt_r) &&
                          (CW'(d_r) + CW'(1) == det_cnt_r);
  assign sts.j_last     = (j_r == dim);
  assign sts.owner_zero = (q_own == '0);
  assign sts.prev_zero  = (h_pred == '0);
  assign sts.i_last     = (i_r == dim);
  assign sts.k_last     = (CW'(k_r) + CW'(1) == det_cnt_r);
  assign sts.out_fire   = out_tready && (cmd.emit_show || cmd.empty_show);

  assign o_det_idx = cmd.empty_show ? 4'd0 : 4'(k_r);
  assign o_matched = cmd.emit_show && match_q_r;
  assign o_trk_idx = o_matched ? 4'(res_trk_q_r) : 4'd0;
  assign o_cost    = o_matched ? res_cost_q_r : '0;
  assign o_empty   = cmd.empty_show;
  assign o_ovf     = ovf_r;

endmodule

// File: hw/rtl/min_cost_track_assignment.sv
// Min-cost track to detection assignment, top level: stream ports, APB register.
// Loads are accepted while the block is idle. A solve computes every distance, clears the
// N+1 column records, then per row sets them up and runs search steps and then path steps
// (N = max(D,T)), then reads out the assignment; each result is read from its store
// before it is shown. Synchronous active-low reset clears counts, overflow and tolerance
// (1024); stores are not cleared. Uses mcta_pkg, mcta_ctrl, mcta_datapath.
module min_cost_track_assignment
  import mcta_pkg::*;
#(
  parameter int MAX_ITEMS  = 16,
  parameter int COORD_BITS = 24
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_tvalid,
  output logic in_tready,
  // pos_x, pos_y, pos_z, zero pad
  input  logic [((3*COORD_BITS+7)/8)*8-1:0] in_tdata,
  // operation
  input  logic [1:0] in_tuser,
  output logic out_tvalid,
  input  logic out_tready,
  // detection_index, track_index, matched, match_cost, overflowed, zero pad
  output logic [OUT_DW-1:0] out_tdata,
  // empty_set
  output logic out_tuser,
  output logic out_tlast,
  input  logic cfg_psel,
  input  logic cfg_penable,
  input  logic cfg_pwrite,
  input  logic [2:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic cfg_pready
);

  cmd_t cmd;
  sts_t sts;
  logic [COST_W-1:0] tol_r;
  logic [3:0] det_idx, trk_idx;
  logic matched, empty, ovf;
  logic [COST_W-1:0] cost;

  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && (cfg_paddr[2] == REG_TOL)) begin
      tol_r <= cfg_pwdata[COST_W-1:0];
    end
  end

  assign cfg_prdata = (cfg_paddr[2] == REG_TOL) ? 32'(tol_r) : 32'd0;

  mcta_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .sts   (sts),
    .cmd   (cmd)
  );

  mcta_datapath #(
    .MAX_ITEMS  (MAX_ITEMS),
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_tvalid  (in_tvalid),
    .in_op      (in_tuser),
    .in_pos     (in_tdata[3*COORD_BITS-1:0]),
    .out_tready (out_tready),
    .tol        (tol_r),
    .o_det_idx  (det_idx),
    .o_trk_idx  (trk_idx),
    .o_matched  (matched),
    .o_cost     (cost),
    .o_empty    (empty),
    .o_ovf      (ovf)
  );

  assign in_tready  = cmd.idle;
  assign out_tvalid = cmd.emit_show | cmd.empty_show;
  assign out_tdata  = {5'd0, ovf, cost, matched, trk_idx, det_idx};
  assign out_tuser  = empty;
  assign out_tlast  = empty | (cmd.emit_show & sts.k_last);

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("input taken while result pending");
  a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> out_tlast) else $error("empty result not last");
  a_unmatched_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tdata[8]) |-> (out_tdata[33:4] == 30'd0))
    else $error("unmatched result carries track or cost");
  a_within_tol: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[8]) |-> (out_tdata[33:9] <= tol_r))
    else $error("match above tolerance");

endmodule

// File: sim/mcta_checker.sv
// Checker for min_cost_track_assignment: watches the input, result and register
// ports, predicts each solve's results and compares them in order.
// Depends on mcta_pkg for operation codes and cost limits.
module mcta_checker
  import mcta_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [71:0] in_tdata,
  input  logic [1:0]  in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [39:0] out_tdata,
  input  logic        out_tuser,
  input  logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  input  logic        cfg_pready,
  output int          fails,
  output int          pending
);

  localparam int NMAX = 16;
  localparam longint BIG = longint'(1) << 60;

  typedef struct packed {
    logic [3:0]        det_idx;
    logic [3:0]        trk_idx;
    logic              matched;
    logic [COST_W-1:0] cost;
    logic              empty;
    logic              ovf;
    logic              last;
  } assign_res_t;

  assign_res_t exp_buf [256];
  logic [7:0] exp_wr, exp_rd;
  longint trk_pos[NMAX][3];
  longint det_pos[NMAX][3];
  longint unsigned cost_m[NMAX][NMAX];
  longint row_pot[NMAX+1], col_pot[NMAX+1], slack[NMAX+1];
  int owner[NMAX+1], pred[NMAX+1];
  bit seen[NMAX+1];
  int n_trk, n_det;
  bit ovf_flag;
  logic [COST_W-1:0] tolerance;

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint padded(int r, int c);
    if (r == 0 || c == 0 || r > n_det || c > n_trk) return 0;
    return longint'(cost_m[r-1][c-1]);
  endfunction

  task automatic put_expected(assign_res_t e);
    exp_buf[exp_wr] = e;
    exp_wr = exp_wr + 8'd1;
  endtask

  task automatic hungarian();
    int dim, cur, row, nxt, prv;
    longint delta, red, dx, dy, dz;
    longint unsigned s;
    dim = (n_det > n_trk) ? n_det : n_trk;
    for (int i = 0; i < n_det; i++)
      for (int j = 0; j < n_trk; j++) begin
        dx = det_pos[i][0] - trk_pos[j][0];
        dy = det_pos[i][1] - trk_pos[j][1];
        dz = det_pos[i][2] - trk_pos[j][2];
        s = dx * dx + dy * dy + dz * dz;
        s = isqrt(s);
        cost_m[i][j] = (s > COST_MAX) ? COST_MAX : s;
      end
    for (int j = 0; j <= NMAX; j++) begin
      row_pot[j] = 0;
      col_pot[j] = 0;
      owner[j] = 0;
      pred[j] = 0;
    end
    for (int i = 1; i <= dim; i++) begin
      cur = 0;
      owner[0] = i;
      for (int j = 0; j <= dim; j++) begin
        slack[j] = BIG;
        seen[j] = 0;
      end
      while (owner[cur] != 0) begin
        row = owner[cur];
        nxt = 0;
        delta = BIG;
        seen[cur] = 1;
        for (int j = 1; j <= dim; j++)
          if (!seen[j]) begin
            red = padded(row, j) - row_pot[row] - col_pot[j];
            if (red < slack[j]) begin
              slack[j] = red;
              pred[j] = cur;
            end
            if (slack[j] < delta) begin
              delta = slack[j];
              nxt = j;
            end
          end
        for (int j = 0; j <= dim; j++)
          if (seen[j]) begin
            row_pot[owner[j]] += delta;
            col_pot[j] -= delta;
          end else begin
            slack[j] -= delta;
          end
        cur = nxt;
      end
      while (cur != 0) begin
        prv = pred[cur];
        owner[cur] = owner[prv];
        cur = prv;
      end
    end
  endtask

  task automatic predict_assignment();
    assign_res_t res[NMAX];
    assign_res_t e;
    int dim, r;
    if (n_det == 0) begin
      e = '0;
      e.empty = 1'b1;
      e.ovf = ovf_flag;
      e.last = 1'b1;
      put_expected(e);
    end else begin
      for (int k = 0; k < n_det; k++) begin
        res[k] = '0;
        res[k].det_idx = 4'(k);
        res[k].ovf = ovf_flag;
        res[k].last = (k + 1 == n_det);
      end
      if (n_trk != 0) begin
        hungarian();
        dim = (n_det > n_trk) ? n_det : n_trk;
        for (int t = 1; t <= dim; t++) begin
          r = owner[t];
          if (r > 0 && r <= n_det && t <= n_trk && cost_m[r-1][t-1] <= tolerance) begin
            res[r-1].trk_idx = 4'(t - 1);
            res[r-1].matched = 1'b1;
            res[r-1].cost = COST_W'(cost_m[r-1][t-1]);
          end
        end
      end
      for (int k = 0; k < n_det; k++) put_expected(res[k]);
    end
    n_trk = 0;
    n_det = 0;
    ovf_flag = 0;
  endtask

  task automatic compare_result();
    assign_res_t e;
    if (exp_wr == exp_rd) begin
      $error("unexpected result beat %h", out_tdata);
      fails++;
      return;
    end
    e = exp_buf[exp_rd];
    exp_rd = exp_rd + 8'd1;
    if (out_tdata[3:0] != e.det_idx) begin
      $error("detection_index exp %0d got %0d", e.det_idx, out_tdata[3:0]);
      fails++;
    end
    if (out_tdata[7:4] != e.trk_idx) begin
      $error("track_index exp %0d got %0d", e.trk_idx, out_tdata[7:4]);
      fails++;
    end
    if (out_tdata[8] != e.matched) begin
      $error("matched exp %0d got %0d", e.matched, out_tdata[8]);
      fails++;
    end
    if (out_tdata[33:9] != e.cost) begin
      $error("match_cost exp %0d got %0d", e.cost, out_tdata[33:9]);
      fails++;
    end
    if (out_tdata[34] != e.ovf) begin
      $error("overflowed exp %0d got %0d", e.ovf, out_tdata[34]);
      fails++;
    end
    if (out_tuser != e.empty) begin
      $error("empty_set exp %0d got %0d", e.empty, out_tuser);
      fails++;
    end
    if (out_tlast != e.last) begin
      $error("last exp %0d got %0d", e.last, out_tlast);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    pending = 0;
    exp_wr = '0;
    exp_rd = '0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      n_trk = 0;
      n_det = 0;
      ovf_flag = 0;
      tolerance = TOL_RESET;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == 3'd0)
        tolerance = cfg_pwdata[COST_W-1:0];
      if (in_tvalid && in_tready) begin
        case (in_tuser)
          OP_LOAD_TRK: begin
            if (n_trk >= NMAX) begin
              ovf_flag = 1;
            end else begin
              trk_pos[n_trk][0] = longint'($signed(in_tdata[23:0]));
              trk_pos[n_trk][1] = longint'($signed(in_tdata[47:24]));
              trk_pos[n_trk][2] = longint'($signed(in_tdata[71:48]));
              n_trk++;
            end
          end
          OP_LOAD_DET: begin
            if (n_det >= NMAX) begin
              ovf_flag = 1;
            end else begin
              det_pos[n_det][0] = longint'($signed(in_tdata[23:0]));
              det_pos[n_det][1] = longint'($signed(in_tdata[47:24]));
              det_pos[n_det][2] = longint'($signed(in_tdata[71:48]));
              n_det++;
            end
          end
          OP_SOLVE: predict_assignment();
          default: ;
        endcase
      end
      if (out_tvalid && out_tready) compare_result();
    end
    pending <= int'(8'(exp_wr - exp_rd));
  end

endmodule

// File: sim/tb.sv
// Top of the min_cost_track_assignment testbench: clock, reset, stimulus,
// register writes, result back-pressure and verdict. Uses mcta_pkg and mcta_checker.
module tb;
  import mcta_pkg::*;

  localparam int LIMIT = 4000000;
  localparam logic [23:0] CMAX = 24'h7fffff;
  localparam logic [23:0] CMIN = 24'h800000;

  logic clk, rst_n;
  logic in_tvalid, in_tready;
  logic [71:0] in_tdata;
  logic [1:0] in_tuser;
  logic out_tvalid, out_tready;
  logic [39:0] out_tdata;
  logic out_tuser, out_tlast;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata, cfg_prdata;
  logic cfg_pready;
  int fails, pending, in_beats, cycles, n_items;
  bit quiet, hold_req;

  min_cost_track_assignment dut (.*);

  mcta_checker chk (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser, .out_tlast,
    .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr, .cfg_pwdata, .cfg_pready,
    .fails, .pending
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (in_tvalid && in_tready) in_beats <= in_beats + 1;
    if (cycles > LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  initial begin
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_tready <= 1'b0;
        repeat (40000) @(negedge clk);
        hold_req = 0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
        repeat ($urandom_range(1, 18) - 1) @(negedge clk);
      end
    end
  end

  task automatic send(logic [1:0] op, logic [23:0] x, logic [23:0] y, logic [23:0] z);
    int target;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk);
    end
    target = in_beats + 1;
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {z, y, x};
    do @(negedge clk); while (in_beats != target);
    n_items++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    repeat (50) @(negedge clk);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [31:0] val);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [23:0] near(logic [23:0] c, int spread);
    if ($urandom_range(0, 7) == 0) return 24'($urandom);
    return c + 24'($urandom_range(0, 2 * spread) - spread);
  endfunction

  task automatic run_set(int nt, int nd, int spread);
    int ti, di;
    logic [23:0] cx, cy, cz;
    ti = 0;
    di = 0;
    cx = 24'($urandom);
    cy = 24'($urandom);
    cz = 24'($urandom);
    while (ti < nt || di < nd) begin
      if ($urandom_range(0, 9) == 0)
        send(2'd3, 24'($urandom), 24'($urandom), 24'($urandom));
      if (di >= nd || (ti < nt && $urandom_range(0, 1) == 0)) begin
        send(OP_LOAD_TRK, near(cx, spread), near(cy, spread), near(cz, spread));
        ti++;
      end else begin
        send(OP_LOAD_DET, near(cx, spread), near(cy, spread), near(cz, spread));
        di++;
      end
    end
    send(OP_SOLVE, 24'($urandom), 24'($urandom), 24'($urandom));
  endtask

  task automatic random_phase(int items, int spread);
    int nt, nd;
    while (n_items < items) begin
      if ($urandom_range(0, 11) == 0) begin
        nt = $urandom_range(13, 17);
        nd = $urandom_range(13, 17);
      end else begin
        nt = $urandom_range(0, 5);
        nd = $urandom_range(0, 5);
      end
      run_set(nt, nd, spread);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    cycles = 0;
    in_beats = 0;
    n_items = 0;
    quiet = 0;
    hold_req = 0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    send(OP_SOLVE, '0, '0, '0);
    send(2'd3, CMAX, CMAX, CMAX);
    send(OP_LOAD_TRK, CMAX, CMAX, CMAX);
    send(OP_LOAD_DET, CMIN, CMIN, CMIN);
    send(OP_SOLVE, '0, '0, '0);
    send(OP_LOAD_TRK, '0, '0, '0);
    send(OP_LOAD_TRK, 24'd1024, '0, '0);
    send(OP_SOLVE, '0, '0, '0);
    send(OP_LOAD_DET, '0, '0, '0);
    send(OP_LOAD_DET, 24'd5, 24'd5, 24'd5);
    send(OP_SOLVE, '0, '0, '0);
    send(OP_LOAD_TRK, '0, '0, 24'd1024);
    send(OP_LOAD_TRK, 24'd3, 24'd4, '0);
    send(OP_LOAD_DET, '0, '0, '0);
    send(OP_LOAD_DET, '0, '0, 24'd1025);
    send(OP_LOAD_DET, 24'd2048, 24'd2048, 24'd2048);
    send(OP_SOLVE, '0, '0, '0);
    drain();

    write_reg(3'd0, 32'h01ffffff);
    write_reg(3'd4, 32'd0);
    send(OP_LOAD_TRK, CMAX, CMAX, CMAX);
    send(OP_LOAD_DET, CMIN, CMIN, CMIN);
    send(OP_SOLVE, '0, '0, '0);
    drain();

    write_reg(3'd0, 32'd0);
    random_phase(80, 2048);
    drain();

    write_reg(3'd0, 32'd1024);
    hold_req = 1;
    run_set(16, 16, 1500);
    run_set(3, 3, 1500);
    hold_req = 0;
    random_phase(170, 1500);
    drain();

    write_reg(3'd0, 32'h01ffffff);
    random_phase(230, 4096);
    drain();

    write_reg(3'd0, 32'($urandom_range(512, 3072)));
    random_phase(280, 2048);
    quiet = 1;
    random_phase(315, 2048);
    drain();
    repeat (200) @(negedge clk);

    if (fails == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
